// File: hdl/sms_pkg.sv
// Shared codes and widths for the startup milestone sequencer.
package sms_pkg;

   localparam int unsigned CMD_W       = 2;
   localparam int unsigned MILESTONE_W = 4;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned PHASE_W     = 4;
   localparam int unsigned SEEN_W      = 10;
   localparam int unsigned REVISION_W  = 32;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 1;

   // Milestone codes with a role of their own
   localparam logic [MILESTONE_W-1:0] MS_FIRST     = 4'd0;
   localparam logic [MILESTONE_W-1:0] MS_PRE_FRAME = 4'd4;
   localparam logic [MILESTONE_W-1:0] MS_CORE_LAST = 4'd6;
   localparam logic [MILESTONE_W-1:0] MS_FRAME     = 4'd7;
   localparam logic [MILESTONE_W-1:0] MS_INPUT     = 4'd8;
   localparam logic [MILESTONE_W-1:0] MS_AUDIO     = 4'd9;

   typedef enum logic [CMD_W-1:0] {
      CMD_RECORD       = 2'd0,
      CMD_FAIL         = 2'd1,
      CMD_BEGIN_STOP   = 2'd2,
      CMD_MARK_STOPPED = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_APPLIED   = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_REJECTED  = 2'd2
   } status_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_CREATED   = 4'd0,
      PH_CORE1     = 4'd1,
      PH_CORE2     = 4'd2,
      PH_CORE3     = 4'd3,
      PH_CORE4     = 4'd4,
      PH_CORE5     = 4'd5,
      PH_CORE6     = 4'd6,
      PH_APP_READY = 4'd7,
      PH_READY     = 4'd8,
      PH_FAILURE   = 4'd9,
      PH_STOPPING  = 4'd10,
      PH_STOPPED   = 4'd11
   } phase_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NEED_FRAME = 2'd0,
      CSR_NEED_INPUT = 2'd1,
      CSR_NEED_AUDIO = 2'd2
   } csr_index_type;

endpackage

// File: hdl/sms_chan_ifs.sv
// Request and response channel interfaces of the startup milestone sequencer.
interface sms_req_if;
   import sms_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CMD_W-1:0]       cmd;
   logic [MILESTONE_W-1:0] milestone;

   modport source (output valid, output cmd, output milestone, input ready);
   modport sink   (input valid, input cmd, input milestone, output ready);
endinterface

interface sms_rsp_if;
   import sms_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [PHASE_W-1:0]    phase;
   logic [SEEN_W-1:0]     seen_mask;
   logic [REVISION_W-1:0] revision;

   modport source (output valid, output status, output phase, output seen_mask,
                   output revision, input ready);
   modport sink   (input valid, input status, input phase, input seen_mask,
                   input revision, output ready);
endinterface

// File: hdl/startup_milestone_sequencer_unit.sv
// Startup milestone sequencer: lifecycle phase, milestone set and revision counter.
//
// Takes one command beat per clock while the response side is not stalled and returns one
// response beat per command, in order. A command lands in an input register; when the
// result register is free or its response is being taken, the phase, milestone set and
// revision counter are updated and the response (status plus the state after the step)
// is loaded into the result register, so each command passes the input register and then
// the result register. Sustained rate is one command per cycle while the response side is
// not stalled; both registers advance together, so a stalled response holds back only one
// further command. Configuration writes (csr_index 0..2: need frame, need input, need
// audio, bit 0 of csr_wdata) take effect on the next command processed; other indexes
// are ignored.
module startup_milestone_sequencer_unit (
   input  logic                               clock,
   input  logic                               reset,
   sms_req_if.sink                            req_chan,
   sms_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [sms_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sms_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import sms_pkg::*;

   // Configuration
   logic need_frame_ff, need_input_ff, need_audio_ff;

   // Input register
   logic                   in_valid_ff;
   cmd_type                in_cmd_ff;
   logic [MILESTONE_W-1:0] in_ms_ff;

   // Sequencer state
   phase_type             phase_ff, phase_in;
   logic [SEEN_W-1:0]     seen_ff, seen_in;
   logic [REVISION_W-1:0] revision_ff, revision_in;

   // Result register
   logic                  out_valid_ff;
   status_type            out_status_ff, status_in;
   phase_type             out_phase_ff;
   logic [SEEN_W-1:0]     out_seen_ff;
   logic [REVISION_W-1:0] out_revision_ff;

   logic out_free, step, in_take;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign step     = in_valid_ff && out_free;
   assign in_take  = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || step;

   // Next-state logic for the command in the input register
   logic                   bump;
   logic                   record_ok;
   logic                   terminal;
   logic [PHASE_W-1:0]     expected;
   logic [SEEN_W-1:0]      ms_bit;
   logic                   missing;

   always_comb begin
      status_in = ST_APPLIED;
      phase_in  = phase_ff;
      seen_in   = seen_ff;
      bump      = 1'b0;
      record_ok = 1'b0;
      terminal  = (phase_ff == PH_FAILURE) || (phase_ff == PH_STOPPING) ||
                  (phase_ff == PH_STOPPED);
      expected  = (phase_ff <= PH_CORE6) ? PHASE_W'(phase_ff) : PHASE_W'(MS_CORE_LAST);
      ms_bit    = SEEN_W'(1) << in_ms_ff;

      case (in_cmd_ff)
         CMD_RECORD: begin
            if (in_ms_ff > MS_AUDIO) begin
               status_in = ST_REJECTED;
               phase_in  = PH_FAILURE;
               bump      = 1'b1;
            end else if ((seen_ff & ms_bit) != '0) begin
               status_in = ST_DUPLICATE;
            end else if (terminal) begin
               status_in = ST_REJECTED;
            end else if (in_ms_ff <= MS_CORE_LAST) begin
               if (in_ms_ff != expected) begin
                  status_in = ST_REJECTED;
                  phase_in  = PH_FAILURE;
                  bump      = 1'b1;
               end else begin
                  seen_in   = seen_ff | ms_bit;
                  phase_in  = phase_type'(in_ms_ff + MILESTONE_W'(1));
                  bump      = 1'b1;
                  record_ok = 1'b1;
               end
            end else if (!seen_ff[MS_FIRST] ||
                         (in_ms_ff == MS_FRAME && !seen_ff[MS_PRE_FRAME])) begin
               status_in = ST_REJECTED;
               phase_in  = PH_FAILURE;
               bump      = 1'b1;
            end else begin
               seen_in   = seen_ff | ms_bit;
               bump      = 1'b1;
               record_ok = 1'b1;
            end
         end
         CMD_FAIL: begin
            if (phase_ff == PH_FAILURE) begin
               status_in = ST_DUPLICATE;
            end else if (phase_ff == PH_STOPPED) begin
               status_in = ST_REJECTED;
            end else begin
               phase_in = PH_FAILURE;
               bump     = 1'b1;
            end
         end
         CMD_BEGIN_STOP: begin
            if (phase_ff == PH_STOPPING || phase_ff == PH_STOPPED) begin
               status_in = ST_DUPLICATE;
            end else begin
               phase_in = PH_STOPPING;
               bump     = 1'b1;
            end
         end
         CMD_MARK_STOPPED: begin
            if (phase_ff == PH_STOPPED) begin
               status_in = ST_DUPLICATE;
            end else if (phase_ff != PH_STOPPING) begin
               status_in = ST_REJECTED;
               phase_in  = PH_FAILURE;
               bump      = 1'b1;
            end else begin
               phase_in = PH_STOPPED;
               bump     = 1'b1;
            end
         end
         default: begin
            status_in = ST_REJECTED;
         end
      endcase

      // Once the last core milestone is in, settle on app ready or ready
      missing = (need_frame_ff && !seen_in[MS_FRAME]) ||
                (need_input_ff && !seen_in[MS_INPUT]) ||
                (need_audio_ff && !seen_in[MS_AUDIO]);
      if (record_ok && seen_in[MS_CORE_LAST]) begin
         phase_in = missing ? PH_APP_READY : PH_READY;
      end

      revision_in = revision_ff + REVISION_W'(bump);
   end

   // Control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         need_frame_ff <= 1'b0;
         need_input_ff <= 1'b0;
         need_audio_ff <= 1'b0;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         phase_ff      <= PH_CREATED;
         seen_ff       <= '0;
         revision_ff   <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_NEED_FRAME: need_frame_ff <= csr_wdata[0];
               CSR_NEED_INPUT: need_input_ff <= csr_wdata[0];
               CSR_NEED_AUDIO: need_audio_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (step) begin
            phase_ff    <= phase_in;
            seen_ff     <= seen_in;
            revision_ff <= revision_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_cmd_ff <= cmd_type'(req_chan.cmd);
         in_ms_ff  <= req_chan.milestone;
      end
      if (step) begin
         out_status_ff   <= status_in;
         out_phase_ff    <= phase_in;
         out_seen_ff     <= seen_in;
         out_revision_ff <= revision_in;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.status    = STATUS_W'(out_status_ff);
   assign rsp_chan.phase     = PHASE_W'(out_phase_ff);
   assign rsp_chan.seen_mask = out_seen_ff;
   assign rsp_chan.revision  = out_revision_ff;

endmodule
